### hdl/rvx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg: shared definitions for the RV32IM subset execute block
// Opcodes, function codes, status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned XLEN          = 32;
  localparam int unsigned CNT_W         = $clog2(XLEN);

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_LUI    = 7'h37;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_HALF = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [4:0]  REG_A0     = 5'd10;
  localparam logic [4:0]  REG_A1     = 5'd11;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ECALL   = 2'd1;
  localparam logic [1:0] STAT_ILLEGAL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OPA, S_OPB, S_EXEC, S_MUL, S_DIV, S_DIVFIN,
    S_LDREQ, S_LDCAP, S_STORE, S_WB
  } state_e;

  typedef enum logic [2:0] {
    K_WB, K_MUL, K_DIV, K_LOAD, K_STORE
  } kind_e;

endpackage
`default_nettype wire

### hdl/riscv_subset_instruction_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riscv_subset_instruction_execute: multicycle RV32IM subset executor
// Executes one instruction word per transfer against a local PC, register
// file and byte-addressed data memory, and returns one result per word.
// ----------------------------------------------------------------------------
// The input channel takes one instruction word per transfer; the output
// channel returns status, next PC, register write and ecall arguments.
// A small sequencer drives one register file read port, one ALU, one
// multiplier and one restoring divider that takes one quotient bit per cycle.
// Each word passes S_OPA, S_OPB and S_EXEC, then by kind S_MUL, the S_DIV
// loop and S_DIVFIN, an S_LDREQ and S_LDCAP pair per load byte or an S_STORE
// per store byte, and ends at S_WB. When MEM_BYTES is not a power of two the
// address is reduced on the divider before each load and store.
// The block takes a new word only once the previous one is complete.
// After reset the data memory is cleared one byte per cycle, and in_ready_o
// stays low meanwhile. A finished result is held in the output register;
// while the receiver stalls, the next word is still taken and executed, and
// it waits at write-back until the output register is free.
// ----------------------------------------------------------------------------
module riscv_subset_instruction_execute #(
  parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] instr_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      next_pc_o,
  output logic             reg_write_valid_o,
  output logic [4:0]       reg_write_index_o,
  output logic [31:0]      reg_write_value_o,
  output logic [31:0]      service_number_o,
  output logic [31:0]      service_argument_o
);
  import rvx_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam bit          POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
  localparam logic [AW:0] MEMSZ = (AW + 1)'(MEM_BYTES);
  localparam logic [AW-1:0] MEMLAST = AW'(MEM_BYTES - 1);

  state_e state_q, state_d;

  logic [31:0] instr_q, pc_q, a_q, b_q, res_q, npc_q;
  logic [1:0]  stat_q;
  logic        wr_q;
  logic [31:0] dq_q, dv_q, rm_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]  bc_q;
  logic [AW-1:0] clr_q, maddr_q;
  logic        out_valid_q;

  logic [31:0] rf_q [XLEN];
  logic [31:0] rf_valid_q;
  logic [31:0] rf_rdata_q;
  logic        rf_rvalid_q;
  logic [4:0]  rf_raddr;
  logic        rf_we;
  logic [31:0] rfv;

  logic [7:0]  mem_q [MEM_BYTES];
  logic [7:0]  mem_rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, byte_addr;
  logic [7:0]  mem_wdata;
  logic [AW:0] bsum;

  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, shamt;
  logic [31:0] iimm, simm, bimm, jimm, opnd, alu, eff;
  logic        dec_ill, dec_wrk, dec_wr;
  kind_e       dec_kind;
  logic [31:0] dec_val, dec_npc;
  logic [1:0]  dec_stat;

  logic signed [63:0] prod;
  logic [32:0] dsh;
  logic        dge;
  logic [31:0] div_res;
  logic        byte_last;
  logic [31:0] ld_word, ld_val;
  logic        wb_fire, is_mem, is_load;

  assign op    = instr_q[6:0];
  assign f3    = instr_q[14:12];
  assign f7    = instr_q[31:25];
  assign rd    = instr_q[11:7];
  assign iimm  = {{20{instr_q[31]}}, instr_q[31:20]};
  assign simm  = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
  assign bimm  = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
                  instr_q[11:8], 1'b0};
  assign jimm  = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
                  instr_q[30:21], 1'b0};
  assign opnd  = (op == OPC_OP) ? b_q : iimm;
  assign shamt = (op == OPC_OP) ? b_q[4:0] : instr_q[24:20];
  assign eff   = a_q + ((op == OPC_STORE) ? simm : iimm);
  assign rfv   = rf_rvalid_q ? rf_rdata_q : '0;
  assign is_load = (op == OPC_LOAD);
  assign is_mem  = is_load || (op == OPC_STORE);

  always_comb begin
    case (f3)
      F3_ADD:  alu = ((op == OPC_OP) && (f7 == F7_ALT)) ? a_q - opnd : a_q + opnd;
      F3_SLL:  alu = a_q << shamt;
      F3_SLT:  alu = {31'd0, $signed(a_q) < $signed(opnd)};
      F3_XOR:  alu = a_q ^ opnd;
      F3_SR:   alu = (f7 == F7_ALT) ? 32'($signed(a_q) >>> shamt) : a_q >> shamt;
      F3_OR:   alu = a_q | opnd;
      F3_AND:  alu = a_q & opnd;
      default: alu = '0;
    endcase
  end

  always_comb begin
    dec_ill  = 1'b0;
    dec_kind = K_WB;
    dec_wrk  = 1'b0;
    dec_val  = alu;
    dec_npc  = pc_q + 32'd4;
    dec_stat = STAT_OK;
    case (op)
      OPC_OP: begin
        dec_wrk = 1'b1;
        case (f7)
          F7_BASE: dec_ill = (f3 == F3_SLTU);
          F7_MULDIV: begin
            case (f3)
              F3_MUL, F3_MULH: dec_kind = K_MUL;
              F3_DIV, F3_REM:  dec_kind = K_DIV;
              default:         dec_ill = 1'b1;
            endcase
          end
          F7_ALT:  dec_ill = (f3 != F3_ADD) && (f3 != F3_SR);
          default: dec_ill = 1'b1;
        endcase
      end
      OPC_IMM: begin
        dec_wrk = 1'b1;
        dec_ill = (f3 == F3_SLTU) || ((f3 == F3_SLL) && (f7 != F7_BASE)) ||
                  ((f3 == F3_SR) && (f7 != F7_BASE) && (f7 != F7_ALT));
      end
      OPC_SYSTEM: begin
        dec_ill  = (instr_q != ECALL_WORD);
        dec_stat = STAT_ECALL;
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  if (a_q == b_q) dec_npc = pc_q + bimm;
          F3_BNE:  if (a_q != b_q) dec_npc = pc_q + bimm;
          default: dec_ill = 1'b1;
        endcase
      end
      OPC_JAL: begin
        dec_wrk = 1'b1;
        dec_val = pc_q + 32'd4;
        dec_npc = pc_q + jimm;
      end
      OPC_LUI: begin
        dec_wrk = 1'b1;
        dec_val = {instr_q[31:12], 12'd0};
      end
      OPC_LOAD: begin
        dec_wrk  = 1'b1;
        dec_kind = K_LOAD;
        dec_ill  = (f3 != F3_BYTE) && (f3 != F3_HALF) && (f3 != F3_WORD);
      end
      OPC_STORE: begin
        dec_kind = K_STORE;
        dec_ill  = (f3 != F3_BYTE) && (f3 != F3_HALF) && (f3 != F3_WORD);
      end
      default: dec_ill = 1'b1;
    endcase
    if (dec_ill) begin
      dec_stat = STAT_ILLEGAL;
      dec_npc  = pc_q;
      dec_wrk  = 1'b0;
      dec_kind = K_WB;
    end
  end
  assign dec_wr = dec_wrk && (rd != 5'd0);

  assign prod = $signed(a_q) * $signed(b_q);
  assign dsh  = {rm_q, dq_q[31]};
  assign dge  = dsh >= {1'b0, dv_q};

  always_comb begin
    if (b_q == 32'd0) begin
      div_res = (f3 == F3_REM) ? a_q : '1;
    end else if (f3 == F3_REM) begin
      div_res = a_q[31] ? 32'd0 - rm_q : rm_q;
    end else begin
      div_res = (a_q[31] ^ b_q[31]) ? 32'd0 - dq_q : dq_q;
    end
  end

  assign bsum      = {1'b0, maddr_q} + {{(AW - 1){1'b0}}, bc_q};
  assign byte_addr = (bsum >= MEMSZ) ? AW'(bsum - MEMSZ) : bsum[AW-1:0];
  assign byte_last = (bc_q == ((f3 == F3_WORD) ? 2'd3 : {1'b0, f3[0]}));

  always_comb begin
    ld_word = res_q;
    ld_word[8*bc_q +: 8] = mem_rdata_q;
    case (f3)
      F3_BYTE: ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      F3_HALF: ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  assign wb_fire = (state_q == S_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == MEMLAST) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_OPA;
      S_OPA:   state_d = S_OPB;
      S_OPB:   state_d = S_EXEC;
      S_EXEC: begin
        case (dec_kind)
          K_MUL:   state_d = S_MUL;
          K_DIV:   state_d = S_DIV;
          K_LOAD:  state_d = POW2 ? S_LDREQ : S_DIV;
          K_STORE: state_d = POW2 ? S_STORE : S_DIV;
          default: state_d = S_WB;
        endcase
      end
      S_MUL:   state_d = S_WB;
      S_DIV:   if (cnt_q == CNT_W'(XLEN - 1)) state_d = S_DIVFIN;
      S_DIVFIN: begin
        if (is_load) begin
          state_d = S_LDREQ;
        end else if (is_mem) begin
          state_d = S_STORE;
        end else begin
          state_d = S_WB;
        end
      end
      S_LDREQ: state_d = S_LDCAP;
      S_LDCAP: state_d = byte_last ? S_WB : S_LDREQ;
      S_STORE: if (byte_last) state_d = S_WB;
      S_WB:    if (wb_fire) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rf_we      = wb_fire && wr_q;
    if (state_q == S_IDLE) begin
      rf_raddr = (instr_word_i[6:0] == OPC_SYSTEM) ? REG_A0 : instr_word_i[19:15];
    end else begin
      rf_raddr = (op == OPC_SYSTEM) ? REG_A1 : instr_q[24:20];
    end
    mem_we    = (state_q == S_CLEAR) || (state_q == S_STORE);
    mem_waddr = (state_q == S_CLEAR) ? clr_q : byte_addr;
    mem_wdata = (state_q == S_CLEAR) ? 8'd0 : b_q[8*bc_q +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= '0;
      cnt_q       <= '0;
      bc_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= '0;
      rf_rvalid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rf_rvalid_q <= rf_valid_q[rf_raddr] && (rf_raddr != 5'd0);
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_EXEC) begin
        cnt_q <= '0;
        bc_q  <= '0;
      end
      if (state_q == S_DIV) cnt_q <= cnt_q + CNT_W'(1);
      if ((state_q == S_LDCAP) || (state_q == S_STORE)) bc_q <= bc_q + 2'd1;
      if (wb_fire) begin
        pc_q        <= npc_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) rf_valid_q[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE:  if (in_valid_i) instr_q <= instr_word_i;
      S_OPA:   a_q <= rfv;
      S_OPB:   b_q <= rfv;
      S_EXEC: begin
        stat_q <= dec_stat;
        wr_q   <= dec_wr;
        res_q  <= dec_val;
        npc_q  <= dec_npc;
        rm_q   <= '0;
        if (dec_kind == K_DIV) begin
          dq_q <= a_q[31] ? 32'd0 - a_q : a_q;
          dv_q <= b_q[31] ? 32'd0 - b_q : b_q;
        end else begin
          dq_q <= eff;
          dv_q <= 32'(MEM_BYTES);
        end
        maddr_q <= eff[AW-1:0];
      end
      S_MUL:   res_q <= (f3 == F3_MULH) ? prod[63:32] : prod[31:0];
      S_DIV: begin
        dq_q <= {dq_q[30:0], dge};
        rm_q <= dge ? 32'(dsh - {1'b0, dv_q}) : dsh[31:0];
      end
      S_DIVFIN: begin
        maddr_q <= rm_q[AW-1:0];
        if (!is_mem) res_q <= div_res;
      end
      S_LDCAP: res_q <= byte_last ? ld_val : ld_word;
      default: ;
    endcase
    if (wb_fire) begin
      status_o           <= stat_q;
      next_pc_o          <= npc_q;
      reg_write_valid_o  <= wr_q;
      reg_write_index_o  <= wr_q ? rd : 5'd0;
      reg_write_value_o  <= wr_q ? res_q : 32'd0;
      service_number_o   <= (stat_q == STAT_ECALL) ? a_q : 32'd0;
      service_argument_o <= (stat_q == STAT_ECALL) ? b_q : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rd] <= res_q;
    rf_rdata_q <= rf_q[rf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem_q[byte_addr];
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |=> state_q == S_DIV || state_q == S_DIVFIN)
    else $error("divider left its loop early");
  a_ill_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire && stat_q == STAT_ILLEGAL |=> pc_q == $past(pc_q))
    else $error("illegal instruction moved the PC");
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_write_valid_o |-> reg_write_index_o != 5'd0)
    else $error("write to register zero reported");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the RV32IM subset execute block
// Drives instruction words through the input channel in random bursts,
// predicts each result with a local model of PC, registers and memory,
// and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rvx_pkg::*;

  localparam int unsigned MEMSZ = 65536;
  localparam int unsigned WATCHDOG = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        wr_valid;
    logic [4:0]  wr_index;
    logic [31:0] wr_value;
    logic [31:0] svc_num;
    logic [31:0] svc_arg;
  } exec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [31:0] instr_word_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, reg_write_valid_o;
  logic [1:0] status_o;
  logic [31:0] next_pc_o, reg_write_value_o, service_number_o, service_argument_o;
  logic [4:0] reg_write_index_o;

  logic [31:0] pending_words[$];
  exec_result_t expected_results[$];
  logic [31:0] model_pc;
  logic [31:0] model_regs[32];
  logic [7:0] model_mem[MEMSZ];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int accepted_count = 0;
  bit long_hold_done = 1'b0;

  riscv_subset_instruction_execute dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] reg_rd(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : model_regs[idx];
  endfunction

  function automatic logic [31:0] signed_div_rem(logic [31:0] a, logic [31:0] b, bit rem);
    if (b == 32'd0) return rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return rem ? 32'd0 : 32'h8000_0000;
    if (rem) return $signed(a) % $signed(b);
    return $signed(a) / $signed(b);
  endfunction

  function automatic exec_result_t execute_word(logic [31:0] w);
    exec_result_t r;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [4:0] rd, sh;
    logic [31:0] a, b, iimm, npc, val, addr, off;
    logic [63:0] prod;
    bit wr, ill;
    int n;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = reg_rd(w[19:15]); b = reg_rd(w[24:20]);
    iimm = {{20{w[31]}}, w[31:20]}; sh = w[24:20];
    npc = model_pc + 32'd4; val = '0; wr = 1'b0; ill = 1'b0;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD: val = a + b;
            F3_SLL: val = a << b[4:0];
            F3_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_XOR: val = a ^ b;
            F3_SR: val = a >> b[4:0];
            F3_OR: val = a | b;
            F3_AND: val = a & b;
            default: ill = 1'b1;
          endcase
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            F3_MUL: val = a * b;
            F3_MULH: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              val = prod[63:32];
            end
            F3_DIV: val = signed_div_rem(a, b, 1'b0);
            F3_REM: val = signed_div_rem(a, b, 1'b1);
            default: ill = 1'b1;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
        else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[4:0];
        else ill = 1'b1;
      end
      OPC_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD: val = a + iimm;
          F3_SLL: if (f7 == F7_BASE) val = a << sh; else ill = 1'b1;
          F3_SLT: val = ($signed(a) < $signed(iimm)) ? 32'd1 : 32'd0;
          F3_XOR: val = a ^ iimm;
          F3_SR: begin
            if (f7 == F7_BASE) val = a >> sh;
            else if (f7 == F7_ALT) val = $signed(a) >>> sh;
            else ill = 1'b1;
          end
          F3_OR: val = a | iimm;
          F3_AND: val = a & iimm;
          default: ill = 1'b1;
        endcase
      end
      OPC_SYSTEM: begin
        if (w != ECALL_WORD) ill = 1'b1;
        else begin
          r.status = STAT_ECALL;
          r.svc_num = reg_rd(REG_A0);
          r.svc_arg = reg_rd(REG_A1);
        end
      end
      OPC_BRANCH: begin
        off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        if (f3 == F3_BEQ) begin
          if (a == b) npc = model_pc + off;
        end else if (f3 == F3_BNE) begin
          if (a != b) npc = model_pc + off;
        end else ill = 1'b1;
      end
      OPC_JAL: begin
        off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        wr = 1'b1; val = model_pc + 32'd4; npc = model_pc + off;
      end
      OPC_LUI: begin
        wr = 1'b1; val = {w[31:12], 12'd0};
      end
      OPC_LOAD: begin
        wr = 1'b1; addr = a + iimm;
        case (f3)
          F3_BYTE: val = {{24{model_mem[addr % MEMSZ][7]}}, model_mem[addr % MEMSZ]};
          F3_HALF: begin
            val[15:0] = {model_mem[(addr + 1) % MEMSZ], model_mem[addr % MEMSZ]};
            val[31:16] = {16{val[15]}};
          end
          F3_WORD: val = {model_mem[(addr + 3) % MEMSZ], model_mem[(addr + 2) % MEMSZ],
                          model_mem[(addr + 1) % MEMSZ], model_mem[addr % MEMSZ]};
          default: ill = 1'b1;
        endcase
      end
      OPC_STORE: begin
        addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_BYTE: n = 1;
          F3_HALF: n = 2;
          F3_WORD: n = 4;
          default: begin n = 0; ill = 1'b1; end
        endcase
        for (int i = 0; i < n; i++) model_mem[(addr + i) % MEMSZ] = b[8*i +: 8];
      end
      default: ill = 1'b1;
    endcase
    if (ill) begin
      r = '0;
      r.status = STAT_ILLEGAL;
      npc = model_pc;
      wr = 1'b0;
    end
    if (wr && rd != 5'd0) begin
      model_regs[rd] = val;
      r.wr_valid = 1'b1; r.wr_index = rd; r.wr_value = val;
    end
    model_pc = npc;
    r.next_pc = npc;
    return r;
  endfunction

  function automatic logic [31:0] r_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // Mostly legal words with random fields, some pure noise.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0] ops[8];
    int pick;
    ops = '{OPC_OP, OPC_IMM, OPC_SYSTEM, OPC_BRANCH, OPC_JAL, OPC_STORE, OPC_LOAD, OPC_LUI};
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) return w;
    if (pick < 11) return ECALL_WORD;
    w[6:0] = ops[$urandom_range(0, 7)];
    if (w[6:0] == OPC_OP && $urandom_range(0, 3) != 0)
      w[31:25] = (w[25]) ? F7_MULDIV : (w[26] ? F7_ALT : F7_BASE);
    if (w[6:0] == OPC_IMM && (w[13:12] == 2'b01) && $urandom_range(0, 3) != 0)
      w[31:25] = w[27] ? F7_ALT : F7_BASE;
    if ((w[6:0] == OPC_LOAD || w[6:0] == OPC_STORE) && $urandom_range(0, 3) != 0)
      w[14:12] = 3'($urandom_range(0, 2));
    if (w[6:0] == OPC_BRANCH && $urandom_range(0, 3) != 0) w[14:13] = 2'b00;
    return w;
  endfunction

  initial begin
    logic [31:0] w;
    for (int i = 0; i < 32; i++) model_regs[i] = '0;
    for (int i = 0; i < MEMSZ; i++) model_mem[i] = '0;
    model_pc = '0;
    pending_words.push_back(r_word(7'd0, 5'd0, 5'd0, 3'd0, 5'd1, OPC_LUI) | 32'h8000_0000);
    pending_words.push_back(r_word(7'h7F, 5'h1F, 5'd0, F3_ADD, 5'd2, OPC_IMM));
    pending_words.push_back(r_word(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP));
    pending_words.push_back(r_word(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd4, OPC_OP));
    pending_words.push_back(r_word(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd5, OPC_OP));
    pending_words.push_back(r_word(F7_MULDIV, 5'd0, 5'd1, F3_REM, 5'd6, OPC_OP));
    pending_words.push_back(r_word(F7_MULDIV, 5'd1, 5'd1, F3_MULH, 5'd7, OPC_OP));
    pending_words.push_back(r_word(F7_MULDIV, 5'd2, 5'd2, F3_MUL, 5'd8, OPC_OP));
    pending_words.push_back(r_word(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd9, OPC_OP));
    pending_words.push_back(r_word(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd10, OPC_IMM));
    pending_words.push_back(r_word(F7_BASE, 5'd2, 5'd1, F3_SLL, 5'd11, OPC_OP));
    pending_words.push_back(r_word(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd0, OPC_OP));
    pending_words.push_back(r_word(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd12, OPC_OP));
    pending_words.push_back(r_word(7'h7F, 5'd2, 5'd0, F3_WORD, 5'h1F, OPC_STORE));
    pending_words.push_back(r_word(7'h7F, 5'h1F, 5'd0, F3_WORD, 5'd13, OPC_LOAD));
    pending_words.push_back(r_word(7'h7F, 5'h1F, 5'd0, F3_BYTE, 5'd14, OPC_LOAD));
    pending_words.push_back(r_word(7'h7F, 5'h1F, 5'd0, F3_HALF, 5'd15, OPC_LOAD));
    pending_words.push_back(ECALL_WORD);
    pending_words.push_back(32'h0010_0073);
    pending_words.push_back(r_word(F7_BASE, 5'd0, 5'd0, F3_BEQ, 5'd8, OPC_BRANCH));
    pending_words.push_back(r_word(F7_BASE, 5'd2, 5'd1, F3_BNE, 5'd8, OPC_BRANCH));
    pending_words.push_back(32'hFFFF_F0EF);
    pending_words.push_back(r_word(F7_MULDIV, 5'd2, 5'd1, F3_SLTU, 5'd1, OPC_OP));
    pending_words.push_back(r_word(F7_ALT, 5'd2, 5'd1, F3_SLL, 5'd1, OPC_IMM));
    pending_words.push_back(32'hFFFF_FFFF);
    for (int i = 0; i < 1350; i++) begin
      w = random_word();
      pending_words.push_back(w);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(execute_word(instr_word_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          instr_word_i <= pending_words.pop_front();
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    exec_result_t got, exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        accepted_count <= accepted_count + 1;
        got = {status_o, next_pc_o, reg_write_valid_o, reg_write_index_o, reg_write_value_o,
               service_number_o, service_argument_o};
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("Unexpected result transfer %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("Mismatch: st %0d/%0d pc %h/%h wv %b/%b wi %0d/%0d val %h/%h a0 %h/%h a1 %h/%h",
                       exp_r.status, got.status, exp_r.next_pc, got.next_pc,
                       exp_r.wr_valid, got.wr_valid, exp_r.wr_index, got.wr_index,
                       exp_r.wr_value, got.wr_value, exp_r.svc_num, got.svc_num,
                       exp_r.svc_arg, got.svc_arg);
          end
        end
      end
      if (!long_hold_done && accepted_count == 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 7) < 5) || (accepted_count[8:7] == 2'b11);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int tail;
    tail = 0;
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
      if (stimulus_done && expected_results.size() == 0) begin
        tail = tail + 1;
        if (tail >= 100) begin
          if (mismatches == 0) begin
            $display("SUCCESS");
          end else begin
            $display("FAILURE");
          end
          $finish;
        end
      end else begin
        tail = 0;
      end
    end
  end

endmodule

### sim.f
hdl/rvx_pkg.sv
hdl/riscv_subset_instruction_execute.sv
sim/testbench.sv
